// ===== rtl/tmrv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the TMR mid-value voter.
// Used by the top, lane and merge modules; depends on nothing else.
package tmrv_pkg;

    // Parameter defaults
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Register widths and the configuration port
    localparam int MAX_DEV_W   = 31;
    localparam int TIE_W       = 2;
    localparam int MIN_VOTES_W = 16;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_AVG   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOTES = 2'd3;

    localparam logic [MAX_DEV_W-1:0] MAX_DEV_RST = 31'd65536;

    // Sensor health codes
    localparam logic [1:0] HLT_HEALTHY  = 2'd0;
    localparam logic [1:0] HLT_DEGRADED = 2'd1;

    // Voter state codes
    localparam logic [2:0] ST_INIT      = 3'd0;
    localparam logic [2:0] ST_AGREE     = 3'd1;
    localparam logic [2:0] ST_DISAGREE  = 3'd2;
    localparam logic [2:0] ST_DEGRADED  = 3'd3;
    localparam logic [2:0] ST_NO_QUORUM = 3'd4;

    // Confidence levels in tenths
    localparam logic [3:0] CONF_TRIPLE       = 4'd10;
    localparam logic [3:0] CONF_TRIPLE_SPLIT = 4'd7;
    localparam logic [3:0] CONF_PAIR         = 4'd8;
    localparam logic [3:0] CONF_PAIR_SPLIT   = 4'd5;
    localparam logic [3:0] CONF_MIN          = 4'd1;
    localparam logic [3:0] CONF_NONE         = 4'd0;

    // Pair slots: sensors (0,1), (0,2), (1,2)
    localparam int P01 = 0;
    localparam int P02 = 1;
    localparam int P12 = 2;

    typedef struct packed {
        logic used;
        logic degraded;
    } lane_flag_t;

    typedef struct packed {
        logic [3:0] conf;
        logic [2:0] state;
        logic [1:0] active_count;
        logic [2:0] used_mask;
        logic       agree;
        logic       vote_valid;
        logic       status;
    } vote_ctrl_t;

endpackage

// ===== rtl/tmr_mid_value_voter.sv =====
`timescale 1ns / 1ps
// Top level of the TMR mid-value select voter: lanes, pair stage, merge, state.
// Depends on tmrv_pkg, tmrv_lane, tmrv_pair and tmrv_merge.
//
// The voter takes one vote per transfer on the s_ channel (three signed
// fixed-point readings with health codes and a finite mask) and returns one
// result per vote on the m_ channel. It sustains one vote per clock cycle
// while m_ready stays high. The lane and pair logic works on the vote before
// its transfer edge, which loads the first stage. The merge logic runs in the
// next cycle, and the output register and the voter state are written when
// the first stage advances into a free or draining output register. The
// output register holds a result until it is taken. While it waits, the
// first stage can hold one more vote; s_ready is low while that stage is full.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wr_data
// and should only change while no vote is in flight.
module tmr_mid_value_voter #(
    parameter int VALUE_BITS = tmrv_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = tmrv_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [tmrv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmrv_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // vote input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [VALUE_BITS-1:0]        s_value_a,
    input  logic signed [VALUE_BITS-1:0]        s_value_b,
    input  logic signed [VALUE_BITS-1:0]        s_value_c,
    input  logic [1:0]                          s_health_a,
    input  logic [1:0]                          s_health_b,
    input  logic [1:0]                          s_health_c,
    input  logic [2:0]                          s_finite_mask,
    // vote result
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_BITS-1:0]        m_voted_value,
    output logic [VALUE_BITS-1:0]               m_spread,
    output logic [3:0]                          m_confidence_tenths,
    output logic [2:0]                          m_voter_state,
    output logic [1:0]                          m_active_count,
    output logic [2:0]                          m_used_mask,
    output logic                                m_agree,
    output logic                                m_vote_valid,
    output logic                                m_status
);
    import tmrv_pkg::*;

    // Configuration registers
    logic [MAX_DEV_W-1:0]   max_dev_reg;
    logic [TIE_W-1:0]       tie_reg;
    logic                   use_avg_reg;
    logic [MIN_VOTES_W-1:0] min_votes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dev_reg   <= MAX_DEV_RST;
            tie_reg       <= '0;
            use_avg_reg   <= 1'b0;
            min_votes_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_DEV:   max_dev_reg   <= cfg_wr_data[MAX_DEV_W-1:0];
                REG_TIE:       tie_reg       <= cfg_wr_data[TIE_W-1:0];
                REG_USE_AVG:   use_avg_reg   <= cfg_wr_data[0];
                REG_MIN_VOTES: min_votes_reg <= cfg_wr_data[MIN_VOTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: advance the first stage whenever the output register is
    // free or being drained; the input side stays open behind it.
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic s1_adv;
    logic s_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    assign s1_valid_next  = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Stage 1: per-sensor lanes and the three pairwise compares
    logic signed [VALUE_BITS-1:0] in_val  [3];
    logic        [1:0]            in_hlt  [3];
    lane_flag_t                   lane_flag [3];
    logic                         pair_lt   [3];
    logic        [VALUE_BITS-1:0] pair_absd [3];
    logic signed [VALUE_BITS-1:0] pair_avg  [3];

    assign in_val[0] = s_value_a;
    assign in_val[1] = s_value_b;
    assign in_val[2] = s_value_c;
    assign in_hlt[0] = s_health_a;
    assign in_hlt[1] = s_health_b;
    assign in_hlt[2] = s_health_c;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        tmrv_lane u_lane (
            .health (in_hlt[i]),
            .finite (s_finite_mask[i]),
            .flag   (lane_flag[i])
        );
    end

    // Pair slots: (a,b), (a,c), (b,c)
    for (genvar k = 0; k < 3; k++) begin : g_pair
        tmrv_pair #(
            .VALUE_BITS (VALUE_BITS)
        ) u_pair (
            .x        ((k == 2) ? in_val[1] : in_val[0]),
            .y        ((k == 0) ? in_val[1] : in_val[2]),
            .lt       (pair_lt[k]),
            .abs_diff (pair_absd[k]),
            .avg      (pair_avg[k])
        );
    end

    // Stage 1 registers: hold lane and pair results for the merge stage
    logic signed [VALUE_BITS-1:0] val_reg  [3];
    lane_flag_t                   flag_reg [3];
    logic                         lt_reg   [3];
    logic        [VALUE_BITS-1:0] absd_reg [3];
    logic signed [VALUE_BITS-1:0] avg_reg  [3];

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int j = 0; j < 3; j++) begin
                val_reg[j]  <= in_val[j];
                flag_reg[j] <= lane_flag[j];
                lt_reg[j]   <= pair_lt[j];
                absd_reg[j] <= pair_absd[j];
                avg_reg[j]  <= pair_avg[j];
            end
        end
    end

    // Voter state
    logic        [2:0]            cur_state_reg;
    logic        [2:0]            cur_state_next;
    logic        [COUNT_BITS-1:0] vote_count_reg;
    logic        [COUNT_BITS-1:0] vote_count_next;
    logic                         have_last_reg;
    logic                         have_last_next;
    logic signed [VALUE_BITS-1:0] last_good_reg;
    logic signed [VALUE_BITS-1:0] last_good_next;

    // Stage 2: merge the lanes into one vote
    logic signed [VALUE_BITS-1:0] mrg_voted;
    logic        [VALUE_BITS-1:0] mrg_spread;
    vote_ctrl_t                   mrg_ctrl;

    tmrv_merge #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_merge (
        .val             (val_reg),
        .flag            (flag_reg),
        .lt              (lt_reg),
        .absd            (absd_reg),
        .avg             (avg_reg),
        .max_dev         (max_dev_reg),
        .tie             (tie_reg),
        .use_avg         (use_avg_reg),
        .min_votes       (min_votes_reg),
        .cur_state       (cur_state_reg),
        .vote_count      (vote_count_reg),
        .have_last       (have_last_reg),
        .last_good       (last_good_reg),
        .voted           (mrg_voted),
        .spread          (mrg_spread),
        .ctrl            (mrg_ctrl),
        .state_next      (cur_state_next),
        .vote_count_next (vote_count_next),
        .have_last_next  (have_last_next),
        .last_good_next  (last_good_next)
    );

    // Commit the state only when the vote moves into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_state_reg  <= ST_INIT;
            vote_count_reg <= '0;
            have_last_reg  <= 1'b0;
            last_good_reg  <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv) begin
                cur_state_reg  <= cur_state_next;
                vote_count_reg <= vote_count_next;
                have_last_reg  <= have_last_next;
                last_good_reg  <= last_good_next;
            end
        end
    end

    // Output register
    logic signed [VALUE_BITS-1:0] voted_reg;
    logic        [VALUE_BITS-1:0] spread_reg;
    vote_ctrl_t                   ctrl_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            voted_reg  <= mrg_voted;
            spread_reg <= mrg_spread;
            ctrl_reg   <= mrg_ctrl;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_voted_value       = voted_reg;
    assign m_spread            = spread_reg;
    assign m_confidence_tenths = ctrl_reg.conf;
    assign m_voter_state       = ctrl_reg.state;
    assign m_active_count      = ctrl_reg.active_count;
    assign m_used_mask         = ctrl_reg.used_mask;
    assign m_agree             = ctrl_reg.agree;
    assign m_vote_valid        = ctrl_reg.vote_valid;
    assign m_status            = ctrl_reg.status;

    // Checks
    a_nq_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |->
            (!m_vote_valid && !m_agree && m_spread == '0 &&
             m_voter_state == ST_NO_QUORUM))
        else $error("no-quorum result carries vote data");

    a_valid_conf : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vote_valid) |-> (m_confidence_tenths != CONF_NONE && !m_status))
        else $error("valid vote with zero confidence or no-quorum status");

    a_count_mask : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_active_count) == $countones(m_used_mask)))
        else $error("active count disagrees with used mask");

    a_have_last_sticky : assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(have_last_reg))
        else $error("held value lost without reset");

    a_state_commit : assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(s1_adv) |-> $stable(vote_count_reg))
        else $error("vote count moved without a committed vote");

endmodule

// ===== rtl/tmrv_lane.sv =====
`timescale 1ns / 1ps
// One sensor lane: qualifies a reading from its finite bit and health code.
// Depends on tmrv_pkg.
module tmrv_lane (
    input  logic [1:0]             health,
    input  logic                   finite,
    output tmrv_pkg::lane_flag_t   flag
);
    import tmrv_pkg::*;

    // Health codes two and three mean nothing and count as faulty.
    assign flag.used     = finite && (health == HLT_HEALTHY || health == HLT_DEGRADED);
    assign flag.degraded = finite && (health == HLT_DEGRADED);

endmodule

// ===== rtl/tmrv_pair.sv =====
`timescale 1ns / 1ps
// Pairwise compare of two readings: order, absolute difference, floor average.
// Does not use tmrv_pkg; stands alone.
module tmrv_pair #(
    parameter int VALUE_BITS = 32
) (
    input  logic signed [VALUE_BITS-1:0] x,
    input  logic signed [VALUE_BITS-1:0] y,
    output logic                         lt,
    output logic        [VALUE_BITS-1:0] abs_diff,
    output logic signed [VALUE_BITS-1:0] avg
);
    logic signed [VALUE_BITS:0] x_ext;
    logic signed [VALUE_BITS:0] y_ext;
    logic signed [VALUE_BITS:0] diff_xy;
    logic signed [VALUE_BITS:0] diff_yx;
    logic signed [VALUE_BITS:0] sum;

    assign x_ext   = {x[VALUE_BITS-1], x};
    assign y_ext   = {y[VALUE_BITS-1], y};
    assign diff_xy = x_ext - y_ext;
    assign diff_yx = y_ext - x_ext;
    assign sum     = x_ext + y_ext;

    assign lt       = diff_xy[VALUE_BITS];
    assign abs_diff = lt ? diff_yx[VALUE_BITS-1:0] : diff_xy[VALUE_BITS-1:0];
    // drop the low bit of the widened sum: rounds toward minus infinity
    assign avg      = sum[VALUE_BITS:1];

endmodule

// ===== rtl/tmrv_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: combines lane flags and pair results into one vote and the
// next voter state. Depends on tmrv_pkg.
module tmrv_merge #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic signed [VALUE_BITS-1:0]          val      [3],
    input  tmrv_pkg::lane_flag_t                  flag     [3],
    input  logic                                  lt       [3],
    input  logic        [VALUE_BITS-1:0]          absd     [3],
    input  logic signed [VALUE_BITS-1:0]          avg      [3],
    input  logic        [tmrv_pkg::MAX_DEV_W-1:0]   max_dev,
    input  logic        [tmrv_pkg::TIE_W-1:0]       tie,
    input  logic                                  use_avg,
    input  logic        [tmrv_pkg::MIN_VOTES_W-1:0] min_votes,
    input  logic        [2:0]                     cur_state,
    input  logic        [COUNT_BITS-1:0]          vote_count,
    input  logic                                  have_last,
    input  logic signed [VALUE_BITS-1:0]          last_good,
    output logic signed [VALUE_BITS-1:0]          voted,
    output logic        [VALUE_BITS-1:0]          spread,
    output tmrv_pkg::vote_ctrl_t                  ctrl,
    output logic        [2:0]                     state_next,
    output logic        [COUNT_BITS-1:0]          vote_count_next,
    output logic                                  have_last_next,
    output logic signed [VALUE_BITS-1:0]          last_good_next
);
    import tmrv_pkg::*;

    localparam int CMP_W = (VALUE_BITS > MAX_DEV_W) ? VALUE_BITS : MAX_DEV_W;
    localparam int MV_W  = (COUNT_BITS > MIN_VOTES_W) ? COUNT_BITS : MIN_VOTES_W;

    logic        [2:0]            used;
    logic        [2:0]            degr;
    logic        [1:0]            cnt;
    logic        [1:0]            deg_cnt;
    logic signed [VALUE_BITS-1:0] med;
    logic        [VALUE_BITS-1:0] tri_spread;
    logic signed [VALUE_BITS-1:0] px;
    logic signed [VALUE_BITS-1:0] py;
    logic signed [VALUE_BITS-1:0] pair_avg;
    logic        [VALUE_BITS-1:0] pair_spread;
    logic        [1:0]            ix0;
    logic        [1:0]            ix1;
    logic signed [VALUE_BITS-1:0] pair_val;
    logic signed [VALUE_BITS-1:0] q_voted;
    logic        [VALUE_BITS-1:0] q_spread;
    logic                         q_agree;
    logic        [3:0]            conf_base;
    logic        [3:0]            q_conf;
    logic        [COUNT_BITS-1:0] count_inc;
    logic                         reached;
    logic        [2:0]            q_state;

    assign used    = {flag[2].used, flag[1].used, flag[0].used};
    assign degr    = {flag[2].degraded, flag[1].degraded, flag[0].degraded};
    assign cnt     = 2'($countones(used));
    assign deg_cnt = 2'($countones(used & degr));

    // Median and spread of three from the three pair orderings
    always_comb begin
        if (lt[P01]) begin
            if (lt[P12]) begin
                med = val[1]; tri_spread = absd[P02];
            end else if (lt[P02]) begin
                med = val[2]; tri_spread = absd[P01];
            end else begin
                med = val[0]; tri_spread = absd[P12];
            end
        end else begin
            if (lt[P02]) begin
                med = val[0]; tri_spread = absd[P12];
            end else if (lt[P12]) begin
                med = val[2]; tri_spread = absd[P01];
            end else begin
                med = val[1]; tri_spread = absd[P02];
            end
        end
    end

    // Pick the pair left over when one sensor drops out
    always_comb begin
        case (used)
            3'b101: begin
                px = val[0]; py = val[2]; ix0 = 2'd0; ix1 = 2'd2;
                pair_avg = avg[P02]; pair_spread = absd[P02];
            end
            3'b110: begin
                px = val[1]; py = val[2]; ix0 = 2'd1; ix1 = 2'd2;
                pair_avg = avg[P12]; pair_spread = absd[P12];
            end
            default: begin
                px = val[0]; py = val[1]; ix0 = 2'd0; ix1 = 2'd1;
                pair_avg = avg[P01]; pair_spread = absd[P01];
            end
        endcase
    end

    always_comb begin
        pair_val = pair_avg;
        if (!use_avg && tie == ix0) begin
            pair_val = px;
        end else if (!use_avg && tie == ix1) begin
            pair_val = py;
        end
    end

    assign q_voted  = (cnt == 2'd3) ? med : pair_val;
    assign q_spread = (cnt == 2'd3) ? tri_spread : pair_spread;
    assign q_agree  = CMP_W'(q_spread) <= CMP_W'(max_dev);

    always_comb begin
        if (cnt == 2'd3) begin
            conf_base = q_agree ? CONF_TRIPLE : CONF_TRIPLE_SPLIT;
        end else begin
            conf_base = q_agree ? CONF_PAIR : CONF_PAIR_SPLIT;
        end
    end

    assign q_conf = (conf_base > ({2'b00, deg_cnt} + 4'd1)) ?
                    (conf_base - {2'b00, deg_cnt}) : CONF_MIN;

    assign count_inc = (vote_count == {COUNT_BITS{1'b1}}) ?
                       vote_count : (vote_count + COUNT_BITS'(1));
    assign reached   = MV_W'(count_inc) >= MV_W'(min_votes);

    always_comb begin
        if (!reached) begin
            q_state = cur_state;
        end else if (cnt == 2'd3) begin
            q_state = q_agree ? ST_AGREE : ST_DISAGREE;
        end else begin
            q_state = ST_DEGRADED;
        end
    end

    always_comb begin
        ctrl.active_count = cnt;
        ctrl.used_mask    = used;
        if (cnt[1]) begin
            voted            = q_voted;
            spread           = q_spread;
            ctrl.conf        = q_conf;
            ctrl.state       = q_state;
            ctrl.agree       = q_agree;
            ctrl.vote_valid  = 1'b1;
            ctrl.status      = 1'b0;
            state_next       = q_state;
            vote_count_next  = count_inc;
            have_last_next   = 1'b1;
            last_good_next   = q_voted;
        end else begin
            voted            = have_last ? last_good : '0;
            spread           = '0;
            ctrl.conf        = have_last ? CONF_MIN : CONF_NONE;
            ctrl.state       = ST_NO_QUORUM;
            ctrl.agree       = 1'b0;
            ctrl.vote_valid  = 1'b0;
            ctrl.status      = 1'b1;
            state_next       = ST_NO_QUORUM;
            vote_count_next  = vote_count;
            have_last_next   = have_last;
            last_good_next   = last_good;
        end
    end

endmodule
